// ----- rtl/core/wvosc_pkg.sv -----
// ----------------------------------------------------------------------------
// wvosc_pkg
// Shared types, codes and constants for the wavetable oscillator bank.
// ----------------------------------------------------------------------------
package wvosc_pkg;

    localparam int TABLE_LENGTH_DEF  = 2048;
    localparam int CHANNEL_COUNT_DEF = 8;
    localparam int BAND_COUNT_DEF    = 4;

    localparam int PHASE_FRAC = 16;
    localparam int CFG_IW     = 3;
    localparam int CFG_DW     = 32;

    localparam logic [31:0] STEP_PER_HZ_RESET = 32'd715828;
    localparam logic [22:0] AMP_SCALE_RESET   = 23'd8388607;

    localparam logic [40:0] BAND_EDGE_0 = 41'(440) << 23;
    localparam logic [40:0] BAND_EDGE_1 = 41'(880) << 23;
    localparam logic [40:0] BAND_EDGE_2 = 41'(1760) << 23;

    localparam logic [56:0] TRUNC_BIAS = (57'(1) << 30) - 57'(1);
    localparam logic [23:0] SAMPLE_MAX = 24'h7fffff;
    localparam logic [23:0] SAMPLE_MIN = 24'h800000;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [CFG_IW-1:0] {
        CFG_DETUNE = 3'd0,
        CFG_WAVE1  = 3'd1,
        CFG_WAVE2  = 3'd2,
        CFG_STEP   = 3'd3,
        CFG_AMP    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SHAPE_SAW     = 2'd0,
        SHAPE_SQUARE  = 2'd1,
        SHAPE_TRI     = 2'd2,
        SHAPE_SAW_ALT = 2'd3
    } t_shape;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_BAND,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_V2,
        S_I2,
        S_G2,
        S_ACC,
        S_SCALE,
        S_SAT,
        S_LEFT,
        S_RIGHT
    } t_state;

    typedef struct packed {
        logic               op;
        logic [2:0]         channel;
        logic [23:0]        frequency;
        logic [15:0]        gain;
        logic [3:0]         table_select;
        logic [10:0]        table_address;
        logic signed [15:0] table_word;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         out_channel;
        logic               side;
        logic signed [23:0] sample;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic tbl_wr;
        logic load;
        logic mul;
        logic band;
        logic phase_wr;
        logic rd_en;
        logic rd_voice;
        logic rd_next;
        logic cap_v1;
        logic cap_v2;
        logic interp;
        logic gain;
        logic acc_first;
        logic acc_add;
        logic scale;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_write;
        logic is_sample;
    } t_dp_status;

endpackage

// ----- rtl/core/wvosc_ctrl.sv -----
// ----------------------------------------------------------------------------
// wvosc_ctrl
// Sequencer for the oscillator datapath: accepts words, steps one sample
// through detune, band choice, table reads, interpolation and scaling, and
// presents the left and right output words.
// ----------------------------------------------------------------------------
module wvosc_ctrl
    import wvosc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_out_valid,
    output logic       o_out_side,
    input  logic       i_out_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.is_write) begin
                        o_cmd.tbl_wr = 1'b1;
                    end else if (i_status.is_sample) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_BAND;
            end
            S_BAND: begin
                o_cmd.band     = 1'b1;
                o_cmd.phase_wr = 1'b1;
                n_state        = S_RD0;
            end
            S_RD0: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_next = 1'b1;
                o_cmd.cap_v1  = 1'b1;
                n_state       = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_voice = 1'b1;
                o_cmd.cap_v2   = 1'b1;
                n_state        = S_RD3;
            end
            S_RD3: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_voice = 1'b1;
                o_cmd.rd_next  = 1'b1;
                o_cmd.cap_v1   = 1'b1;
                o_cmd.interp   = 1'b1;
                n_state        = S_V2;
            end
            S_V2: begin
                o_cmd.cap_v2 = 1'b1;
                o_cmd.gain   = 1'b1;
                n_state      = S_I2;
            end
            S_I2: begin
                o_cmd.interp    = 1'b1;
                o_cmd.acc_first = 1'b1;
                n_state         = S_G2;
            end
            S_G2: begin
                o_cmd.gain = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_SAT;
            end
            S_SAT: begin
                o_cmd.finish = 1'b1;
                n_state      = S_LEFT;
            end
            S_LEFT: begin
                if (!i_out_stall) begin
                    n_state = S_RIGHT;
                end
            end
            S_RIGHT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_LEFT) || (r_state == S_RIGHT);
    assign o_out_side  = (r_state == S_RIGHT);

endmodule

// ----- rtl/core/wvosc_dp.sv -----
// ----------------------------------------------------------------------------
// wvosc_dp
// Oscillator datapath: configuration registers, channel phases, wave table
// memory, detune and step multipliers, interpolation, gain, scaling and
// saturation.
// ----------------------------------------------------------------------------
module wvosc_dp
    import wvosc_pkg::*;
#(
    parameter int TABLE_LENGTH  = TABLE_LENGTH_DEF,
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
    parameter int BAND_COUNT    = BAND_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_in_word           i_in_word,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic               i_cfg_we,
    input  logic [CFG_IW-1:0]  i_cfg_idx,
    input  logic [CFG_DW-1:0]  i_cfg_wdata,
    output logic signed [23:0] o_sample,
    output logic [2:0]         o_channel
);

    localparam int LW          = $clog2(TABLE_LENGTH);
    localparam int PW          = LW + PHASE_FRAC;
    localparam int TABLE_COUNT = 2 * BAND_COUNT + 1;
    localparam int TW          = $clog2(TABLE_COUNT);
    localparam int STORE_DEPTH = TABLE_COUNT * TABLE_LENGTH;
    localparam int AW          = TW + LW;
    localparam int CW          = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int BW          = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

    // configuration
    logic [15:0] r_detune;
    t_shape      r_wave1;
    t_shape      r_wave2;
    logic [31:0] r_step_hz;
    logic [22:0] r_amp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detune  <= '0;
            r_wave1   <= SHAPE_SAW;
            r_wave2   <= SHAPE_SAW;
            r_step_hz <= STEP_PER_HZ_RESET;
            r_amp     <= AMP_SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DETUNE: r_detune  <= i_cfg_wdata[15:0];
                CFG_WAVE1:  r_wave1   <= t_shape'(i_cfg_wdata[1:0]);
                CFG_WAVE2:  r_wave2   <= t_shape'(i_cfg_wdata[1:0]);
                CFG_STEP:   r_step_hz <= i_cfg_wdata[31:0];
                CFG_AMP:    r_amp     <= i_cfg_wdata[22:0];
                default: ;
            endcase
        end
    end

    // input decode
    logic w_ch_ok;
    logic w_sel_ok;
    logic w_addr_ok;

    assign w_ch_ok   = ({29'd0, i_in_word.channel} < 32'(CHANNEL_COUNT));
    assign w_sel_ok  = ({28'd0, i_in_word.table_select} < 32'(TABLE_COUNT));
    assign w_addr_ok = ({21'd0, i_in_word.table_address} < 32'(TABLE_LENGTH));

    assign o_status.is_write  = (i_in_word.op == OP_WRITE);
    assign o_status.is_sample = (i_in_word.op == OP_SAMPLE) && w_ch_ok;

    // item registers
    logic [23:0]   r_freq;
    logic [15:0]   r_gain;
    logic [2:0]    r_ch;
    logic [PW-1:0] r_phase;
    logic [PW-1:0] r_phase_mem [CHANNEL_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_freq  <= i_in_word.frequency;
            r_gain  <= i_in_word.gain;
            r_ch    <= i_in_word.channel;
            r_phase <= r_phase_mem[CW'(i_in_word.channel)];
        end
    end

    // detune and phase step
    logic [15:0]   w_up_f;
    logic [16:0]   w_down_f;
    logic [55:0]   w_step_prod;
    logic [39:0]   r_up;
    logic [40:0]   r_down;
    logic [PW-1:0] r_step;

    assign w_up_f      = r_detune ^ 16'h8000;
    assign w_down_f    = 17'h08000 - {r_detune[15], r_detune};
    assign w_step_prod = 56'(r_freq) * 56'(r_step_hz);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_up   <= 40'(r_freq) * 40'(w_up_f);
            r_down <= 41'(r_freq) * 41'(w_down_f);
            r_step <= w_step_prod[PHASE_FRAC +: PW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                r_phase_mem[i] <= '0;
            end
        end else if (i_cmd.phase_wr) begin
            r_phase_mem[CW'(r_ch)] <= r_phase + r_step;
        end
    end

    // band and table choice
    function automatic logic [BW-1:0] pick_band(input logic [40:0] f);
        logic [1:0] cnt;
        cnt = 2'(f >= BAND_EDGE_0) + 2'(f >= BAND_EDGE_1) + 2'(f >= BAND_EDGE_2);
        if (32'(cnt) > 32'(BAND_COUNT - 1)) begin
            return BW'(BAND_COUNT - 1);
        end
        return BW'(cnt);
    endfunction

    function automatic logic [TW-1:0] pick_table(input t_shape s, input logic [BW-1:0] b);
        logic [TW-1:0] t;
        case (s)
            SHAPE_SQUARE: t = TW'(BAND_COUNT) + TW'(b);
            SHAPE_TRI:    t = TW'(2 * BAND_COUNT);
            default:      t = TW'(b);
        endcase
        return t;
    endfunction

    logic [TW-1:0] r_tab1;
    logic [TW-1:0] r_tab2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.band) begin
            r_tab1 <= pick_table(r_wave1, pick_band({1'b0, r_up}));
            r_tab2 <= pick_table(r_wave2, pick_band(r_down));
        end
    end

    // wave table memory
    logic [15:0]   r_mem [STORE_DEPTH];
    logic [15:0]   r_rdata;
    logic          w_wr_en;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [LW-1:0] w_idx;
    logic [LW-1:0] w_nxt;

    assign w_wr_en = i_cmd.tbl_wr && w_sel_ok && w_addr_ok;
    assign w_waddr = {TW'(i_in_word.table_select), LW'(i_in_word.table_address)};
    assign w_idx   = r_phase[PW-1:PHASE_FRAC];
    assign w_nxt   = w_idx + LW'(1);
    assign w_raddr = {(i_cmd.rd_voice ? r_tab2 : r_tab1), (i_cmd.rd_next ? w_nxt : w_idx)};

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_waddr] <= i_in_word.table_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // interpolation, gain, sum
    logic signed [15:0] r_v1;
    logic signed [16:0] w_diff;
    logic signed [33:0] w_dprod;
    logic signed [32:0] r_dprod;
    logic signed [33:0] w_interp;
    logic signed [31:0] r_interp;
    logic signed [48:0] w_gprod;
    logic signed [31:0] r_vprod;
    logic signed [32:0] r_acc;

    assign w_diff   = $signed({r_rdata[15], r_rdata}) - $signed({r_v1[15], r_v1});
    assign w_dprod  = 34'($signed({1'b0, r_phase[PHASE_FRAC-1:0]})) * 34'(w_diff);
    assign w_interp = $signed({{2{r_v1[15]}}, r_v1, 16'd0}) + $signed({r_dprod[32], r_dprod});
    assign w_gprod  = 49'(r_interp) * 49'($signed({1'b0, r_gain}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_v1) begin
            r_v1 <= r_rdata;
        end
        if (i_cmd.cap_v2) begin
            r_dprod <= w_dprod[32:0];
        end
        if (i_cmd.interp) begin
            r_interp <= w_interp[31:0];
        end
        if (i_cmd.gain) begin
            r_vprod <= w_gprod[47:16];
        end
        if (i_cmd.acc_first) begin
            r_acc <= {r_vprod[31], r_vprod};
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + {r_vprod[31], r_vprod};
        end
    end

    // scale, truncate toward zero, saturate
    logic signed [56:0] w_scaled;
    logic signed [56:0] r_scaled;
    logic signed [56:0] w_round;
    logic signed [26:0] w_q;
    logic               w_pos_ovf;
    logic               w_neg_ovf;
    logic signed [23:0] r_sample;

    assign w_scaled  = 57'(r_acc) * 57'($signed({1'b0, r_amp}));
    assign w_round   = r_scaled + (r_scaled[56] ? $signed(TRUNC_BIAS) : 57'sd0);
    assign w_q       = w_round[56:30];
    assign w_pos_ovf = !w_q[26] && (w_q[25:23] != 3'b000);
    assign w_neg_ovf = w_q[26] && (w_q[25:23] != 3'b111);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_scaled <= w_scaled;
        end
        if (i_cmd.finish) begin
            if (w_pos_ovf) begin
                r_sample <= SAMPLE_MAX;
            end else if (w_neg_ovf) begin
                r_sample <= SAMPLE_MIN;
            end else begin
                r_sample <= w_q[23:0];
            end
        end
    end

    assign o_sample  = r_sample;
    assign o_channel = r_ch;

endmodule

// ----- rtl/core/wavetable_oscillator_bank.sv -----
// ----------------------------------------------------------------------------
// wavetable_oscillator_bank
// A table write is accepted while idle and leaves the block idle, ready for
// another word. A sample word occupies the block from acceptance through
// twelve datapath steps, paced by the four reads of the wave table memory's
// single read port and the detune, gain and scale multipliers, then the left
// and right output words, each held until taken. Input words are stalled
// from acceptance of a sample until its right word is taken. A sample word
// for a channel beyond the bank is accepted and dropped. The wave table
// memory has no reset; the channel phases clear to zero at reset.
// ----------------------------------------------------------------------------
module wavetable_oscillator_bank
    import wvosc_pkg::*;
#(
    parameter int TABLE_LENGTH  = TABLE_LENGTH_DEF,
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
    parameter int BAND_COUNT    = BAND_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    t_dp_cmd            w_cmd;
    t_dp_status         w_status;
    logic               w_side;
    logic signed [23:0] w_sample;
    logic [2:0]         w_channel;

    wvosc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .o_out_side  (w_side),
        .i_out_stall (i_out_stall)
    );

    wvosc_dp #(
        .TABLE_LENGTH  (TABLE_LENGTH),
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .BAND_COUNT    (BAND_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sample    (w_sample),
        .o_channel   (w_channel)
    );

    assign o_out_word.out_channel = w_channel;
    assign o_out_word.side        = w_side;
    assign o_out_word.sample      = w_sample;
    assign o_out_word.last        = w_side;

    a_left_then_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_word.side)
        |=> (o_out_valid && o_out_word.side && o_out_word.last))
        else $error("right word does not follow taken left word");

    a_sample_pair_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_word.side)
        |=> ($stable(o_out_word.sample) && $stable(o_out_word.out_channel)))
        else $error("left and right words differ");

    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while output pending");

    a_sample_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && w_status.is_sample) |=> (o_in_stall && !o_out_valid))
        else $error("accepted sample did not start a run");

endmodule

// ----- verif/wvosc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvosc_checker
// Watches the input, output and register ports of the oscillator bank. Keeps
// its own table memory, channel phases and register copies, predicts the
// left/right sample pair of every accepted sample word, and compares each
// output word field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module wvosc_checker
    import wvosc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  t_in_word          in_word,
    input  logic              out_valid,
    input  logic              out_stall,
    input  t_out_word         out_word,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_idx,
    input  logic [CFG_DW-1:0] cfg_wdata,
    output int                fail_count,
    output int                pending
);

    localparam int LEN       = TABLE_LENGTH_DEF;
    localparam int CHANNELS  = CHANNEL_COUNT_DEF;
    localparam int BANDS     = BAND_COUNT_DEF;
    localparam int TABLES    = 2 * BANDS + 1;
    localparam int SHOW_MAX  = 10;

    localparam longint EDGE_LOW  = longint'(440) << 23;
    localparam longint EDGE_MID  = longint'(880) << 23;
    localparam longint EDGE_HIGH = longint'(1760) << 23;
    localparam longint OUT_MAX   = 64'sd8388607;
    localparam longint OUT_MIN   = -64'sd8388608;

    logic [15:0]        wave_mem [TABLES * LEN];
    logic [26:0]        phase_acc [CHANNELS];
    logic signed [15:0] detune_q15;
    t_shape             shape_one;
    t_shape             shape_two;
    logic [31:0]        step_rate;
    logic [22:0]        amp_scale;

    t_out_word          stereo_pairs [$];
    int                 mismatches;

    function automatic longint voice_term(logic [26:0] ph, longint scaled, t_shape shape,
                                          logic [15:0] gain);
        int          band;
        int          tbl;
        logic [10:0] idx;
        logic [10:0] nxt;
        longint      v1;
        longint      v2;
        longint      interp;
        band = 0;
        if (scaled >= EDGE_LOW) band = 1;
        if (scaled >= EDGE_MID) band = 2;
        if (scaled >= EDGE_HIGH) band = 3;
        if (band > BANDS - 1) band = BANDS - 1;
        case (shape)
            SHAPE_SQUARE: tbl = BANDS + band;
            SHAPE_TRI:    tbl = 2 * BANDS;
            default:      tbl = band;
        endcase
        idx = ph[26:16];
        nxt = idx + 11'd1;
        v1 = longint'($signed(wave_mem[tbl * LEN + int'(idx)]));
        v2 = longint'($signed(wave_mem[tbl * LEN + int'(nxt)]));
        interp = v1 * 65536 + longint'(ph[15:0]) * (v2 - v1);
        return (interp * longint'(gain)) >>> 16;
    endfunction

    function automatic logic [23:0] mixed_sample(logic [26:0] ph, logic [23:0] freq,
                                                 logic [15:0] gain);
        longint up;
        longint down;
        longint total;
        longint scaled;
        longint q;
        up = longint'(freq) * (longint'(32768) + longint'(detune_q15));
        down = longint'(freq) * (longint'(32768) - longint'(detune_q15));
        total = voice_term(ph, up, shape_one, gain) + voice_term(ph, down, shape_two, gain);
        scaled = total * longint'(amp_scale);
        if (scaled < 0) q = -((-scaled) >>> 30);
        else q = scaled >>> 30;
        if (q > OUT_MAX) q = OUT_MAX;
        if (q < OUT_MIN) q = OUT_MIN;
        return q[23:0];
    endfunction

    always @(posedge clk) begin : track
        t_out_word   want;
        logic [23:0] smp;
        logic [63:0] step;
        int          ch;
        if (!rst_n) begin
            foreach (phase_acc[i]) phase_acc[i] = '0;
            detune_q15 = '0;
            shape_one  = SHAPE_SAW;
            shape_two  = SHAPE_SAW;
            step_rate  = STEP_PER_HZ_RESET;
            amp_scale  = AMP_SCALE_RESET;
            stereo_pairs.delete();
            mismatches = 0;
        end else begin
            if (cfg_we) begin
                case (t_cfg_idx'(cfg_idx))
                    CFG_DETUNE: detune_q15 = cfg_wdata[15:0];
                    CFG_WAVE1:  shape_one  = t_shape'(cfg_wdata[1:0]);
                    CFG_WAVE2:  shape_two  = t_shape'(cfg_wdata[1:0]);
                    CFG_STEP:   step_rate  = cfg_wdata;
                    CFG_AMP:    amp_scale  = cfg_wdata[22:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                if (in_word.op == OP_WRITE) begin
                    if (int'(in_word.table_select) < TABLES &&
                        int'(in_word.table_address) < LEN)
                        wave_mem[int'(in_word.table_select) * LEN + int'(in_word.table_address)]
                            = in_word.table_word;
                end else if (int'(in_word.channel) < CHANNELS) begin
                    ch = int'(in_word.channel);
                    smp = mixed_sample(phase_acc[ch], in_word.frequency, in_word.gain);
                    want.out_channel = in_word.channel;
                    want.sample = smp;
                    want.side = 1'b0;
                    want.last = 1'b0;
                    stereo_pairs.push_back(want);
                    want.side = 1'b1;
                    want.last = 1'b1;
                    stereo_pairs.push_back(want);
                    step = (64'(in_word.frequency) * 64'(step_rate)) >> 16;
                    phase_acc[ch] = phase_acc[ch] + step[26:0];
                end
            end
            if (out_valid && !out_stall) begin
                if (stereo_pairs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("%0t: unexpected word ch=%0d side=%0d sample=%0d last=%0d",
                                 $realtime, out_word.out_channel, out_word.side,
                                 out_word.sample, out_word.last);
                end else begin
                    want = stereo_pairs.pop_front();
                    if (out_word.out_channel !== want.out_channel ||
                        out_word.side !== want.side ||
                        out_word.sample !== want.sample ||
                        out_word.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= SHOW_MAX) begin
                            $write("%0t: mismatch exp ch=%0d side=%0d sample=%0d last=%0d",
                                   $realtime, want.out_channel, want.side, want.sample,
                                   want.last);
                            $display(" got ch=%0d side=%0d sample=%0d last=%0d",
                                     out_word.out_channel, out_word.side,
                                     out_word.sample, out_word.last);
                        end
                    end
                end
            end
        end
        pending <= stereo_pairs.size();
        fail_count <= mismatches;
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the wavetable oscillator bank: fills every table, runs a
// directed set of edge cases, then random phases under several register
// settings and idle/stall patterns. The checker predicts and compares; this
// module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import wvosc_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 185;
    localparam int TABLE_WORDS  = (2 * BAND_COUNT_DEF + 1) * TABLE_LENGTH_DEF;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    t_in_word          in_word;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_word         out_word;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_idx;
    logic [CFG_DW-1:0] cfg_wdata;
    int                fail_count;
    int                pending;
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    int                idle_cycles = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    wavetable_oscillator_bank u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    wvosc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(logic [15:0] detune, t_shape s1, t_shape s2,
                                 logic [31:0] step, logic [22:0] amp);
        t_cfg_idx    idx [5];
        logic [31:0] val [5];
        idx = '{CFG_DETUNE, CFG_WAVE1, CFG_WAVE2, CFG_STEP, CFG_AMP};
        val = '{32'(detune), 32'(s1), 32'(s2), step, 32'(amp)};
        for (int i = 0; i < 5; i++) begin
            cfg_we <= 1'b1;
            cfg_idx <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] table_value();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_word write_word(int sel, int addr, logic [15:0] value);
        t_in_word w;
        w = '0;
        w.op = OP_WRITE;
        w.table_select = 4'(sel);
        w.table_address = 11'(addr);
        w.table_word = value;
        return w;
    endfunction

    function automatic t_in_word sample_word(int ch, logic [23:0] freq, logic [15:0] gain);
        t_in_word w;
        w = '0;
        w.op = OP_SAMPLE;
        w.channel = 3'(ch);
        w.frequency = freq;
        w.gain = gain;
        return w;
    endfunction

    function automatic t_in_word random_word();
        logic [95:0] raw;
        t_in_word    w;
        raw = {$urandom, $urandom, $urandom};
        w = t_in_word'(raw[$bits(t_in_word)-1:0]);
        w.table_word = table_value();
        if ($urandom_range(3) == 0) begin
            w.op = OP_WRITE;
            if ($urandom_range(9) == 0) w.table_select = 4'($urandom_range(15, 9));
            else w.table_select = 4'($urandom_range(8));
        end else begin
            w.op = OP_SAMPLE;
            if ($urandom_range(1) == 0) w.frequency = 24'($urandom_range(2000 * 256));
        end
        return w;
    endfunction

    initial begin
        int          items;
        logic [31:0] step;
        logic [22:0] amp;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_word <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_DETUNE;
        cfg_wdata <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_settings(16'h0000, SHAPE_SAW, SHAPE_SAW, STEP_PER_HZ_RESET, AMP_SCALE_RESET);

        // fill every table so no sample reads an unwritten entry
        for (int i = 0; i < TABLE_WORDS; i++)
            send_word(write_word(i / TABLE_LENGTH_DEF, i % TABLE_LENGTH_DEF, table_value()));

        send_word(write_word(0, 0, 16'h8000));
        send_word(write_word(8, TABLE_LENGTH_DEF - 1, 16'h7fff));
        send_word(write_word(7, 1, 16'h0000));
        send_word(write_word(9, 5, 16'h1234));
        send_word(write_word(15, TABLE_LENGTH_DEF - 1, 16'hffff));
        send_word(sample_word(0, 24'd0, 16'h0000));
        send_word(sample_word(7, 24'hffffff, 16'hffff));
        send_word(sample_word(1, 24'(440 * 256), 16'h8000));
        send_word(sample_word(2, 24'(440 * 256 - 1), 16'h8000));
        send_word(sample_word(3, 24'(880 * 256), 16'hffff));
        send_word(sample_word(3, 24'(880 * 256 - 1), 16'hffff));
        send_word(sample_word(4, 24'(1760 * 256), 16'h7fff));
        send_word(sample_word(5, 24'(1760 * 256 - 1), 16'hffff));
        send_word(sample_word(0, 24'hffffff, 16'hffff));
        send_word(sample_word(6, 24'd1, 16'd1));
        send_word(sample_word(7, 24'h800000, 16'h8000));
        wait_for_results();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 85; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 85; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            items = PHASE_ITEMS;
            if (p == 0) begin
                load_settings(16'h8000, SHAPE_SAW, SHAPE_SQUARE, 32'hffffffff, 23'h7fffff);
            end else if (p == 1) begin
                load_settings(16'h7fff, SHAPE_TRI, SHAPE_SAW_ALT, 32'd0, 23'd0);
                items = 40;
            end else begin
                step = ($urandom_range(1) == 0) ? $urandom : 32'($urandom_range(4000000));
                amp = ($urandom_range(2) == 0) ? 23'h7fffff : 23'($urandom);
                load_settings(16'($urandom), t_shape'($urandom_range(3)),
                              t_shape'($urandom_range(3)), step, amp);
            end
            for (int i = 0; i < items; i++)
                send_word(random_word());
            wait_for_results();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- wavetable_oscillator_bank.f -----
rtl/core/wvosc_pkg.sv
rtl/core/wvosc_ctrl.sv
rtl/core/wvosc_dp.sv
rtl/core/wavetable_oscillator_bank.sv
verif/wvosc_checker.sv
verif/tb_top.sv
